// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clk edge, quiet while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: src/cswg_pkg.sv
`timescale 1ns / 1ps

package cswg_pkg;

    // Phase accumulator and phase fraction
    localparam int PHASE_BITS = 32;
    localparam int U_W        = 16;

    // Quarter-wave sine table
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_QUARTER     = SINE_TABLE_DEPTH / 4;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_R_W         = SINE_IDX_W - 2;
    localparam int SINE_TAB_W       = SINE_R_W + 1;

    typedef logic [SINE_QUARTER:0][15:0] sine_tab_t;

    // Field widths
    localparam int AMP_W    = 15;
    localparam int BASE_W   = 13;
    localparam int INC_W    = 24;
    localparam int SENSOR_W = 16;
    localparam int SAMPLE_W = 15;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMPLITUDE       = 3'd0,
        CFG_BASELINE        = 3'd1,
        CFG_PHASE_INCREMENT = 3'd2,
        CFG_WAVEFORM_MODE   = 3'd3,
        CFG_USE_EXTERNAL    = 3'd4
    } cfg_reg_t;

    localparam logic [AMP_W-1:0] AMP_RESET = 15'd9728;
    localparam logic [INC_W-1:0] INC_RESET = 24'd1073742;

    // Capnogram breakpoints, Q0.16 of one period
    localparam logic [U_W-1:0] CAP_B0 = 16'd5243;
    localparam logic [U_W-1:0] CAP_B1 = 16'd11796;
    localparam logic [U_W-1:0] CAP_B2 = 16'd36045;
    localparam logic [U_W-1:0] CAP_B3 = 16'd39322;

    localparam int LEN_W = 15;
    localparam logic [LEN_W-1:0] LEN_RISE    = LEN_W'(CAP_B1 - CAP_B0);
    localparam logic [LEN_W-1:0] LEN_PLATEAU = LEN_W'(CAP_B2 - CAP_B1);
    localparam logic [LEN_W-1:0] LEN_FALL    = LEN_W'(CAP_B3 - CAP_B2);

    localparam int DIV_STEPS = U_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Shape constants
    localparam logic [17:0] SMOOTH_K      = 18'd196608;  // 3.0 in Q2.16
    localparam logic [11:0] PLATEAU_SLOPE = 12'd3277;    // 0.05 in Q0.16
    localparam logic [16:0] FALL_GAIN     = 17'd68813;   // 1.05 in Q1.16
    localparam logic [16:0] ONE_Q16       = 17'h10000;

    // Serial multiplier
    localparam int MUL_X_W   = 34;
    localparam int MUL_Y_W   = 18;
    localparam int MUL_P_W   = MUL_X_W + MUL_Y_W;
    localparam int MUL_CNT_W = $clog2(MUL_Y_W);

    typedef struct packed {
        logic               start;
        logic [MUL_X_W-1:0] x;
        logic [MUL_Y_W-1:0] y;
    } mul_cmd_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } mul_rsp_t;

    // Channel words
    typedef struct packed {
        logic                       sensor_valid;
        logic signed [SENSOR_W-1:0] sensor_value;
    } tick_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                from_sensor;
    } result_t;

    // Q2.30 product with truncation of the magnitude
    function automatic longint mul30(input longint a, input longint b);
        logic        neg;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] p;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 64'(-a) : 64'(a);
        ub  = (b < 0) ? 64'(-b) : 64'(b);
        p   = (ua * ub) >> 30;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    // Degree-9 odd polynomial, rounded to Q1.15; evaluated at elaboration
    function automatic sine_tab_t build_sine_table();
        sine_tab_t tab;
        longint    x;
        longint    x2;
        longint    p;
        longint    s;
        tab = '0;
        for (int k = 0; k <= SINE_QUARTER; k++)
        begin
            x  = (longint'(k) <<< 30) / SINE_QUARTER;
            x2 = mul30(x, x);
            p  = 172273;
            p  = -5026995 + mul30(x2, p);
            p  = 85569306 + mul30(x2, p);
            p  = -693598668 + mul30(x2, p);
            p  = 1686629713 + mul30(x2, p);
            s  = mul30(x, p);
            if (s < 0)
            begin
                s = 0;
            end
            s = (s + 16384) >>> 15;
            if (s > 32768)
            begin
                s = 32768;
            end
            tab[k] = 16'(s);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

// File: src/cswg_ser_mul.sv
`timescale 1ns / 1ps

// Shift-add multiplier, one bit of y per cycle, LSB first.
module cswg_ser_mul
    import cswg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_cmd_t cmd,
    output mul_rsp_t rsp
);

    logic [MUL_X_W-1:0]   x_reg;
    logic [MUL_X_W-1:0]   h_reg;
    logic [MUL_Y_W-1:0]   l_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [MUL_X_W:0]     sum;
    logic [MUL_X_W-1:0]   h_next;
    logic [MUL_Y_W-1:0]   l_next;

    always_comb
    begin
        sum    = {1'b0, h_reg} + ({1'b0, x_reg} & {(MUL_X_W + 1){l_reg[0]}});
        h_next = sum[MUL_X_W:1];
        l_next = {sum[0], l_reg[MUL_Y_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            h_reg    <= '0;
            l_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            priority if (cmd.start)
            begin
                x_reg    <= cmd.x;
                h_reg    <= '0;
                l_reg    <= cmd.y;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                h_reg   <= h_next;
                l_reg   <= l_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_Y_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = {h_reg, l_reg};

endmodule

// File: src/capnogram_sine_waveform_generator.sv
// Capnogram / sine waveform generator. Each tick word is one 1 ms tick; every
// accepted tick gives exactly one result word and advances a 32-bit phase
// accumulator by phase_increment (2^32 = one period). With use_external set,
// a tick carrying a valid sensor sample is passed through clamped at zero
// (from_sensor = 1); otherwise the result is baseline plus amplitude times a
// sine (quarter-wave table) or a five-segment capnogram shape, in Q8.8,
// clamped to 0..32767. One tick is worked on at a time and the time it takes
// depends on its path: a passed sample, the flat part of the capnogram, a
// sine sample, or the rise, plateau or fall segment. The paths differ in the
// work they hand to the shared bit-serial multiplier and the 16-step
// restoring divider that maps the phase into a segment; the sine needs one
// product, the fall segment four plus the division. A finished word sits in
// the output register while the next tick is taken in. Configuration is
// written through cfg_* and is taken only while no tick is in flight; a
// pending write holds off the tick channel.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module capnogram_sine_waveform_generator
    import cswg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_stall,
    input  tick_t                 tick,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_MUL_START,
        S_MUL_WAIT,
        S_FINISH,
        S_OUT
    } state_t;

    // Products in the order the shapes need them
    typedef enum logic [2:0] {
        OP_SINE,        // amplitude * |sin|
        OP_SQUARE,      // t * t
        OP_SMOOTH,      // t^2 * (3 - 2t)
        OP_RISE,        // amplitude * smoothstep
        OP_PL_SLOPE,    // 0.05 * t
        OP_PL_SCALE,    // amplitude * slope term
        OP_FALL_GAIN,   // 1.05 * (1 - smoothstep)
        OP_FALL_SCALE   // amplitude * fall gain
    } op_t;

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_PLATEAU,
        SEG_FALL
    } seg_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [AMP_W-1:0]         amp_reg;
    logic signed [BASE_W-1:0] baseline_reg;
    logic [INC_W-1:0]         inc_reg;
    logic                     mode_reg;
    logic                     ext_reg;

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t                   state_reg;
    op_t                      op_reg;
    seg_t                     seg_reg;
    logic [PHASE_BITS-1:0]    phase_reg;
    logic [U_W-1:0]           u_reg;
    tick_t                    sens_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;
    logic [LEN_W-1:0]         rem_reg;
    logic [U_W-1:0]           t_reg;
    logic [MUL_X_W-1:0]       opnd_reg;
    logic [16:0]              sm_reg;
    logic [15:0]              term_reg;
    logic                     neg_reg;
    result_t                  pend_reg;
    result_t                  result_reg;
    logic                     result_valid_reg;

    logic                     tick_accept;
    logic                     cfg_write;
    logic                     out_load;
    logic [PHASE_BITS-1:0]    phase_next;

    logic [SINE_IDX_W-1:0]    sine_i;
    logic [1:0]               sine_quad;
    logic [SINE_R_W-1:0]      sine_r;
    logic [SINE_TAB_W-1:0]    sine_tab_idx;
    logic [15:0]              sine_mag;

    logic                     cap_window;
    seg_t                     seg_sel;
    logic [U_W-1:0]           seg_start;
    logic [LEN_W-1:0]         seg_offset;
    logic [LEN_W-1:0]         div_len;
    logic [LEN_W:0]           rem_dbl;
    logic                     div_ge;
    logic [LEN_W-1:0]         rem_next;
    logic [U_W-1:0]           t_next;

    logic [15:0]              term_next;
    logic [17:0]              term_ext;
    logic [17:0]              gen_value;
    logic [SAMPLE_W-1:0]      gen_sample;
    logic [SAMPLE_W-1:0]      pass_sample;

    mul_cmd_t                 mul_cmd;
    mul_rsp_t                 mul_rsp;

    cswg_ser_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd),
        .rsp   (mul_rsp)
    );

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    // a register write in progress keeps ticks out, so the two never share an edge
    assign tick_stall   = (state_reg != S_IDLE) || cfg_valid;
    assign tick_accept  = tick_valid && !tick_stall;
    assign cfg_ready    = (state_reg == S_IDLE);
    assign cfg_write    = cfg_valid && cfg_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Output register loads a waiting word when empty or being emptied this cycle
    assign out_load = (state_reg == S_OUT) && (!result_valid_reg || !result_stall);

    assign phase_next = phase_reg + PHASE_BITS'(inc_reg);

    // ------------------------------------------------------------------
    // Sine: quadrant from the top two index bits, mirrored in odd ones
    // ------------------------------------------------------------------
    always_comb
    begin
        sine_i       = u_reg[U_W-1 -: SINE_IDX_W];
        sine_quad    = sine_i[SINE_IDX_W-1 -: 2];
        sine_r       = sine_i[SINE_R_W-1:0];
        sine_tab_idx = sine_quad[0] ? (SINE_TAB_W'(SINE_QUARTER) - {1'b0, sine_r})
                                    : {1'b0, sine_r};
        sine_mag     = SINE_TABLE[sine_tab_idx];
    end

    // ------------------------------------------------------------------
    // Capnogram segment selection
    // ------------------------------------------------------------------
    always_comb
    begin
        cap_window = (u_reg >= CAP_B0) && (u_reg < CAP_B3);
        priority if (u_reg < CAP_B1)
        begin
            seg_sel   = SEG_RISE;
            seg_start = CAP_B0;
        end
        else if (u_reg < CAP_B2)
        begin
            seg_sel   = SEG_PLATEAU;
            seg_start = CAP_B1;
        end
        else
        begin
            seg_sel   = SEG_FALL;
            seg_start = CAP_B2;
        end
        // below the segment length, so it fits the remainder width
        seg_offset = LEN_W'(u_reg - seg_start);
    end

    // ------------------------------------------------------------------
    // Restoring divider: t = (offset << 16) / length, one bit a cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (seg_reg)
            SEG_RISE:    div_len = LEN_RISE;
            SEG_PLATEAU: div_len = LEN_PLATEAU;
            SEG_FALL:    div_len = LEN_FALL;
            default:     div_len = LEN_FALL;
        endcase
        rem_dbl  = {rem_reg, 1'b0};
        div_ge   = (rem_dbl >= {1'b0, div_len});
        rem_next = div_ge ? LEN_W'(rem_dbl - {1'b0, div_len}) : rem_dbl[LEN_W-1:0];
        t_next   = {t_reg[U_W-2:0], div_ge};
    end

    // ------------------------------------------------------------------
    // Multiplier operands
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_cmd.start = (state_reg == S_MUL_START);
        unique case (op_reg)
            OP_SINE:
            begin
                mul_cmd.x = opnd_reg;
                mul_cmd.y = MUL_Y_W'(amp_reg);
            end
            OP_SQUARE:
            begin
                mul_cmd.x = MUL_X_W'(t_reg);
                mul_cmd.y = MUL_Y_W'(t_reg);
            end
            OP_SMOOTH:
            begin
                mul_cmd.x = opnd_reg;
                mul_cmd.y = SMOOTH_K - {1'b0, t_reg, 1'b0};
            end
            OP_RISE:
            begin
                mul_cmd.x = MUL_X_W'(sm_reg);
                mul_cmd.y = MUL_Y_W'(amp_reg);
            end
            OP_PL_SLOPE:
            begin
                mul_cmd.x = MUL_X_W'(t_reg);
                mul_cmd.y = MUL_Y_W'(PLATEAU_SLOPE);
            end
            OP_PL_SCALE:
            begin
                mul_cmd.x = opnd_reg;
                mul_cmd.y = MUL_Y_W'(amp_reg);
            end
            OP_FALL_GAIN:
            begin
                mul_cmd.x = MUL_X_W'(ONE_Q16 - sm_reg);
                mul_cmd.y = MUL_Y_W'(FALL_GAIN);
            end
            OP_FALL_SCALE:
            begin
                mul_cmd.x = opnd_reg;
                mul_cmd.y = MUL_Y_W'(amp_reg);
            end
        endcase
    end

    // Rounded shape term taken from the last product of each shape
    always_comb
    begin
        unique case (op_reg)
            OP_SINE:       term_next = mul_rsp.prod[30:15] + 16'(mul_rsp.prod[14]);
            OP_RISE:       term_next = mul_rsp.prod[31:16] + 16'(mul_rsp.prod[15]);
            OP_PL_SCALE:   term_next = 16'(amp_reg) + mul_rsp.prod[47:32]
                                       + 16'(mul_rsp.prod[31]);
            OP_FALL_SCALE: term_next = mul_rsp.prod[47:32] + 16'(mul_rsp.prod[31]);
            default:       term_next = term_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Baseline, sign and saturation
    // ------------------------------------------------------------------
    always_comb
    begin
        term_ext  = {2'b00, term_reg};
        gen_value = {{(18 - BASE_W){baseline_reg[BASE_W-1]}}, baseline_reg}
                    + (neg_reg ? -term_ext : term_ext);
        priority if (gen_value[17])
        begin
            gen_sample = '0;
        end
        else if (|gen_value[16:15])
        begin
            gen_sample = '1;
        end
        else
        begin
            gen_sample = gen_value[SAMPLE_W-1:0];
        end
        pass_sample = sens_reg.sensor_value[SENSOR_W-1] ? '0
                                                        : sens_reg.sensor_value[SAMPLE_W-1:0];
    end

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg      <= AMP_RESET;
            baseline_reg <= '0;
            inc_reg      <= INC_RESET;
            mode_reg     <= 1'b0;
            ext_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_AMPLITUDE:       amp_reg      <= cfg_data[AMP_W-1:0];
                CFG_BASELINE:        baseline_reg <= signed'(cfg_data[BASE_W-1:0]);
                CFG_PHASE_INCREMENT: inc_reg      <= cfg_data[INC_W-1:0];
                CFG_WAVEFORM_MODE:   mode_reg     <= cfg_data[0];
                CFG_USE_EXTERNAL:    ext_reg      <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_SINE;
            seg_reg          <= SEG_RISE;
            phase_reg        <= '0;
            u_reg            <= '0;
            sens_reg         <= '0;
            cnt_reg          <= '0;
            rem_reg          <= '0;
            t_reg            <= '0;
            opnd_reg         <= '0;
            sm_reg           <= '0;
            term_reg         <= '0;
            neg_reg          <= 1'b0;
            pend_reg         <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    // result is formed from the phase before the advance
                    if (tick_accept)
                    begin
                        sens_reg  <= tick;
                        u_reg     <= phase_reg[PHASE_BITS-1 -: U_W];
                        phase_reg <= phase_next;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    priority if (ext_reg && sens_reg.sensor_valid)
                    begin
                        pend_reg  <= '{sample: pass_sample, from_sensor: 1'b1};
                        state_reg <= S_OUT;
                    end
                    else if (!mode_reg)
                    begin
                        opnd_reg  <= MUL_X_W'(sine_mag);
                        neg_reg   <= sine_quad[1];
                        op_reg    <= OP_SINE;
                        state_reg <= S_MUL_START;
                    end
                    else if (!cap_window)
                    begin
                        term_reg  <= '0;
                        neg_reg   <= 1'b0;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        seg_reg   <= seg_sel;
                        rem_reg   <= seg_offset;
                        t_reg     <= '0;
                        cnt_reg   <= '0;
                        neg_reg   <= 1'b0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_next;
                    t_reg   <= t_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    begin
                        op_reg    <= (seg_reg == SEG_PLATEAU) ? OP_PL_SLOPE : OP_SQUARE;
                        state_reg <= S_MUL_START;
                    end
                end
                S_MUL_START:
                begin
                    state_reg <= S_MUL_WAIT;
                end
                S_MUL_WAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        unique case (op_reg)
                            OP_SINE:
                            begin
                                term_reg  <= term_next;
                                state_reg <= S_FINISH;
                            end
                            OP_SQUARE:
                            begin
                                opnd_reg  <= MUL_X_W'(mul_rsp.prod[31:0]);
                                op_reg    <= OP_SMOOTH;
                                state_reg <= S_MUL_START;
                            end
                            OP_SMOOTH:
                            begin
                                // smoothstep in Q1.16, never above one
                                sm_reg    <= mul_rsp.prod[48:32];
                                op_reg    <= (seg_reg == SEG_FALL) ? OP_FALL_GAIN : OP_RISE;
                                state_reg <= S_MUL_START;
                            end
                            OP_RISE:
                            begin
                                term_reg  <= term_next;
                                state_reg <= S_FINISH;
                            end
                            OP_PL_SLOPE:
                            begin
                                opnd_reg  <= MUL_X_W'(mul_rsp.prod[27:0]);
                                op_reg    <= OP_PL_SCALE;
                                state_reg <= S_MUL_START;
                            end
                            OP_PL_SCALE:
                            begin
                                term_reg  <= term_next;
                                state_reg <= S_FINISH;
                            end
                            OP_FALL_GAIN:
                            begin
                                opnd_reg  <= mul_rsp.prod[MUL_X_W-1:0];
                                op_reg    <= OP_FALL_SCALE;
                                state_reg <= S_MUL_START;
                            end
                            OP_FALL_SCALE:
                            begin
                                term_reg  <= term_next;
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_FINISH:
                begin
                    pend_reg  <= '{sample: gen_sample, from_sensor: 1'b0};
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // output word register
            priority if (out_load)
            begin
                result_reg       <= pend_reg;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // phase only moves when a tick word is taken
    `ASSERT_NEXT(a_phase_hold, !tick_accept, $stable(phase_reg), "phase moved without a tick")
    // a product only arrives while the sequencer waits for it
    `ASSERT_CLK(a_mul_done_wait, mul_rsp.done |-> state_reg == S_MUL_WAIT, "stray product")
    // divider remainder stays below the segment length
    `ASSERT_CLK(a_div_rem, state_reg == S_DIV |-> rem_reg < div_len, "divider remainder overflow")

endmodule
